### rtl/bicm_pkg.sv
`default_nettype none

package bicm_pkg;

  localparam int COORD_BITS = 13;
  localparam int REG_BITS   = COORD_BITS + 1;
  // scale mode dividend is dest * image size
  localparam int NUM_W      = COORD_BITS + REG_BITS;
  // one quotient bit per divider stage
  localparam int DIV_STAGES = REG_BITS;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [1:0] {
    MODE_SCALE  = 2'd0,
    MODE_TILE   = 2'd1,
    MODE_CENTER = 2'd2
  } fill_mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FILL_MODE     = 3'd0,
    CFG_SCREEN_WIDTH  = 3'd1,
    CFG_SCREEN_HEIGHT = 3'd2,
    CFG_IMAGE_WIDTH   = 3'd3,
    CFG_IMAGE_HEIGHT  = 3'd4
  } cfg_reg_e;

  // restoring divider state: partial remainder, dividend bits shifting out
  // of low while quotient bits shift in
  typedef struct packed {
    logic [REG_BITS-1:0] dvsr;
    logic [REG_BITS-1:0] rem;
    logic [REG_BITS-1:0] low;
  } div_t;

  // per-axis info that rides alongside the divider
  typedef struct packed {
    logic                  ok;
    logic                  use_rem;
    logic                  use_ctr;
    logic [COORD_BITS-1:0] ctr_src;
  } side_t;

endpackage

`default_nettype wire

### rtl/background_image_coordinate_mapper_core.sv
`default_nettype none

// Maps a screen pixel (dest_x, dest_y) to the image pixel that fills it in
// scale (nearest neighbour), tile or center mode, or flags black fill with
// inside_res low and both source fields zero. Takes one coordinate every
// clock when not stalled. The pipeline is one operand stage (multiply
// for scale mode, center offsets), 14 restoring-divide stages that give the
// scale quotient or the tile remainder one bit each, and the output register.
// The config port is always ready; write it only while no transaction is in
// flight. Index values past image_height are ignored.
module background_image_coordinate_mapper_core import bicm_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [REG_BITS-1:0]     cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [COORD_BITS-1:0]   dest_x_i,
  input  wire logic [COORD_BITS-1:0]   dest_y_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [COORD_BITS-1:0]        source_x_o,
  output logic [COORD_BITS-1:0]        source_y_o,
  output logic                         inside_res_o
);

  logic [1:0]          mode_q;
  logic [REG_BITS-1:0] scr_w_q, scr_h_q, img_w_q, img_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SCALE;
      scr_w_q <= REG_BITS'(1);
      scr_h_q <= REG_BITS'(1);
      img_w_q <= REG_BITS'(1);
      img_h_q <= REG_BITS'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FILL_MODE:     mode_q  <= cfg_data_i[1:0];
        CFG_SCREEN_WIDTH:  scr_w_q <= cfg_data_i;
        CFG_SCREEN_HEIGHT: scr_h_q <= cfg_data_i;
        CFG_IMAGE_WIDTH:   img_w_q <= cfg_data_i;
        CFG_IMAGE_HEIGHT:  img_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stall chain: a stage loads when empty or when the stage after it loads
  logic                  prep_v_q;
  logic [DIV_STAGES-1:0] div_v_q;
  logic                  out_v_q;
  logic                  prep_en, out_en;
  logic [DIV_STAGES-1:0] div_en;

  assign out_en = !out_v_q || !out_stall_i;

  always_comb begin
    div_en[DIV_STAGES-1] = !div_v_q[DIV_STAGES-1] || out_en;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      div_en[k] = !div_v_q[k] || div_en[k+1];
    end
  end

  assign prep_en    = !prep_v_q || div_en[0];
  assign in_stall_o = !prep_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
      div_v_q  <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (prep_en) prep_v_q <= in_valid_i;
      if (div_en[0]) div_v_q[0] <= prep_v_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (div_en[k]) div_v_q[k] <= div_v_q[k-1];
      end
      if (out_en) out_v_q <= div_v_q[DIV_STAGES-1];
    end
  end

  div_t  x_div [DIV_STAGES+1];
  div_t  y_div [DIV_STAGES+1];
  side_t x_side [DIV_STAGES+1];
  side_t y_side [DIV_STAGES+1];

  bicm_prep u_prep_x (
    .clk_i  (clk_i),
    .en_i   (prep_en),
    .mode_i (mode_q),
    .scr_i  (scr_w_q),
    .img_i  (img_w_q),
    .dest_i (dest_x_i),
    .div_o  (x_div[0]),
    .side_o (x_side[0])
  );

  bicm_prep u_prep_y (
    .clk_i  (clk_i),
    .en_i   (prep_en),
    .mode_i (mode_q),
    .scr_i  (scr_h_q),
    .img_i  (img_h_q),
    .dest_i (dest_y_i),
    .div_o  (y_div[0]),
    .side_o (y_side[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    bicm_div_stage u_stage_x (
      .clk_i  (clk_i),
      .en_i   (div_en[g]),
      .div_i  (x_div[g]),
      .side_i (x_side[g]),
      .div_o  (x_div[g+1]),
      .side_o (x_side[g+1])
    );

    bicm_div_stage u_stage_y (
      .clk_i  (clk_i),
      .en_i   (div_en[g]),
      .div_i  (y_div[g]),
      .side_i (y_side[g]),
      .div_o  (y_div[g+1]),
      .side_o (y_side[g+1])
    );
  end

  // after the last step: low holds the quotient, rem the remainder
  logic [COORD_BITS-1:0] src_x, src_y, src_x_d, src_y_d, src_x_q, src_y_q;
  logic                  inside_d, inside_q;

  always_comb begin
    if (x_side[DIV_STAGES].use_ctr) begin
      src_x = x_side[DIV_STAGES].ctr_src;
    end else if (x_side[DIV_STAGES].use_rem) begin
      src_x = x_div[DIV_STAGES].rem[COORD_BITS-1:0];
    end else begin
      src_x = x_div[DIV_STAGES].low[COORD_BITS-1:0];
    end
    if (y_side[DIV_STAGES].use_ctr) begin
      src_y = y_side[DIV_STAGES].ctr_src;
    end else if (y_side[DIV_STAGES].use_rem) begin
      src_y = y_div[DIV_STAGES].rem[COORD_BITS-1:0];
    end else begin
      src_y = y_div[DIV_STAGES].low[COORD_BITS-1:0];
    end
    inside_d = x_side[DIV_STAGES].ok && y_side[DIV_STAGES].ok;
    src_x_d  = inside_d ? src_x : '0;
    src_y_d  = inside_d ? src_y : '0;
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      src_x_q  <= src_x_d;
      src_y_q  <= src_y_d;
      inside_q <= inside_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign source_x_o   = src_x_q;
  assign source_y_o   = src_y_q;
  assign inside_res_o = inside_q;

  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_res_o |-> source_x_o == '0 && source_y_o == '0)
    else $error("black fill with nonzero source coordinate");

  a_empty_out_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> !in_stall_o)
    else $error("input stalled while output stage empty");

  a_last_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v_q[DIV_STAGES-1] && !div_en[DIV_STAGES-1] |=> div_v_q[DIV_STAGES-1])
    else $error("stalled divider stage dropped its transaction");

  a_out_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v_q[DIV_STAGES-1] && out_en |=> out_v_q)
    else $error("output stage missed a transaction from the divider");

endmodule

`default_nettype wire

### rtl/bicm_prep.sv
`default_nettype none

module bicm_prep import bicm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [1:0]            mode_i,
  input  wire logic [REG_BITS-1:0]   scr_i,
  input  wire logic [REG_BITS-1:0]   img_i,
  input  wire logic [COORD_BITS-1:0] dest_i,
  output div_t                       div_o,
  output side_t                      side_o
);

  logic              tile, center;
  logic [NUM_W-1:0]  prod, num;
  logic [REG_BITS:0] s_e, i_e, d_e;
  logic [REG_BITS:0] start, crop, span, rel;
  logic              s_ge_i, ctr_in, base_ok;
  div_t              div_d, div_q;
  side_t             side_d, side_q;

  always_comb begin
    tile   = 1'b0;
    center = 1'b0;
    case (fill_mode_e'(mode_i))
      MODE_TILE:   tile = 1'b1;
      MODE_CENTER: center = 1'b1;
      default: begin
        tile   = 1'b0;
        center = 1'b0;
      end
    endcase
  end

  assign base_ok = (scr_i != '0) && (img_i != '0) && (REG_BITS'(dest_i) < scr_i);

  assign prod = NUM_W'(dest_i) * NUM_W'(img_i);
  assign num  = tile ? NUM_W'(dest_i) : prod;

  // center: offset truncates toward zero, so crop uses the magnitude
  assign s_e    = (REG_BITS + 1)'(scr_i);
  assign i_e    = (REG_BITS + 1)'(img_i);
  assign d_e    = (REG_BITS + 1)'(dest_i);
  assign s_ge_i = scr_i >= img_i;
  assign start  = s_ge_i ? ((s_e - i_e) >> 1) : '0;
  assign crop   = s_ge_i ? '0 : ((i_e - s_e) >> 1);
  assign span   = i_e - (crop << 1);
  assign rel    = d_e - start;
  assign ctr_in = (d_e >= start) && (rel < span) && (span != '0);

  always_comb begin
    div_d.dvsr     = tile ? img_i : scr_i;
    div_d.rem      = REG_BITS'(num[NUM_W-1:REG_BITS]);
    div_d.low      = num[REG_BITS-1:0];
    side_d.ok      = base_ok && (!center || ctr_in);
    side_d.use_rem = tile;
    side_d.use_ctr = center;
    side_d.ctr_src = COORD_BITS'(crop + rel);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q  <= div_d;
      side_q <= side_d;
    end
  end

  assign div_o  = div_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

### rtl/bicm_div_stage.sv
`default_nettype none

module bicm_div_stage import bicm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire div_t  div_i,
  input  wire side_t side_i,
  output div_t       div_o,
  output side_t      side_o
);

  logic [REG_BITS:0] trial, diff;
  logic              ge;
  div_t              div_d, div_q;
  side_t             side_q;

  assign trial = {div_i.rem, div_i.low[REG_BITS-1]};
  assign diff  = trial - {1'b0, div_i.dvsr};
  assign ge    = trial >= {1'b0, div_i.dvsr};

  always_comb begin
    div_d.dvsr = div_i.dvsr;
    div_d.rem  = ge ? diff[REG_BITS-1:0] : trial[REG_BITS-1:0];
    div_d.low  = {div_i.low[REG_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q  <= div_d;
      side_q <= side_i;
    end
  end

  assign div_o  = div_q;
  assign side_o = side_q;

endmodule

`default_nettype wire
